/* rtl/core/sha0_compression_assert.svh */
// ---------------------------------------------------------------------------
// sha0_compression_assert.svh
// Assertion macros shared by the compression core.
// ---------------------------------------------------------------------------
`ifndef SHA0_COMPRESSION_ASSERT_SVH
`define SHA0_COMPRESSION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHA0_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SHA0_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sha0_pkg.sv */
// ---------------------------------------------------------------------------
// sha0_pkg
// Types and constants shared by the SHA-0 compression core.
// ---------------------------------------------------------------------------
package sha0_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_ROUNDS  = 80;
    localparam int ROUND_W     = $clog2(NUM_ROUNDS);
    localparam int WIN_DEPTH   = 16;
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int CHAIN_WORDS = 5;
    localparam int CHAIN_IW    = $clog2(CHAIN_WORDS);
    localparam int RD_PORTS    = 4;

    // schedule taps: W[t-3], W[t-8], W[t-14], W[t-16]
    localparam int TAP_A = 3;
    localparam int TAP_B = 8;
    localparam int TAP_C = 14;

    localparam int PHASE1_END = 20;
    localparam int PHASE2_END = 40;
    localparam int PHASE3_END = 60;

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] IV_WORDS [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic              start_of_message;
        logic              end_of_message;
    } word_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic              digest_last;
    } digest_beat_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic               init_iv;
        logic               load_work;
        logic               round_en;
        logic               add_chain;
        logic [ROUND_W-1:0] round_idx;
    } rnd_ctl_t;

endpackage

/* rtl/core/sha0_compression.sv */
// ---------------------------------------------------------------------------
// sha0_compression
// SHA-0 compression core: word stream in, five-word digest out.
// ---------------------------------------------------------------------------
// Input channel (word_valid / word_stall / word): one 32-bit big-endian word
// of the padded message per beat. start_of_message puts the chaining words
// back to the IV before the word is taken; end_of_message marks the last word.
// Every 16th word of a block starts a compression: 80 rounds, one per cycle,
// then an add into the chaining words. The input is stalled while the rounds
// run and during the add; no new word is taken until the block is through.
// Output channel (digest_valid / digest_stall / digest): after an end word,
// five beats H0..H4, digest_last on the fifth. The first beat is offered the
// cycle after the end word (or after the add cycle if it completed a block).
// Input is stalled until all five beats are taken; a stalled receiver simply
// holds the current digest beat.
// Reset loads the standard IV and returns to accepting words at block word 0.
// ---------------------------------------------------------------------------
module sha0_compression (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   word_valid,
    output logic                   word_stall,
    input  sha0_pkg::word_beat_t   word,
    output logic                   digest_valid,
    input  logic                   digest_stall,
    output sha0_pkg::digest_beat_t digest
);
    import sha0_pkg::*;

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_ADD   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [WIN_AW-1:0]   word_idx_reg, word_idx_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [CHAIN_IW-1:0] emit_reg, emit_next;
    logic                end_pend_reg, end_pend_next;

    logic                word_acc, digest_acc;
    logic [WIN_AW-1:0]   load_idx;
    logic [ROUND_W-1:0]  rd_round;
    logic [WIN_AW-1:0]   rd_lo;
    logic                wr_en;
    logic [WIN_AW-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [WORD_W-1:0]   sched_w;
    logic [RD_PORTS-1:0][WIN_AW-1:0] rd_addr;
    logic [RD_PORTS-1:0][WORD_W-1:0] rd_data;
    rnd_ctl_t            ctl;

    assign word_stall   = (state_reg != S_LOAD);
    assign digest_valid = (state_reg == S_EMIT);
    assign word_acc     = word_valid && !word_stall;
    assign digest_acc   = digest_valid && !digest_stall;
    assign load_idx     = word.start_of_message ? '0 : word_idx_reg;

    // read for the next round in the cycle before it; in the rounds, never hits the entry being written
    assign rd_round = (state_reg == S_ROUND) ? round_reg + ROUND_W'(1) : '0;
    assign rd_lo    = rd_round[WIN_AW-1:0];
    assign rd_addr[0] = (rd_round < ROUND_W'(WIN_DEPTH)) ? rd_lo : rd_lo - WIN_AW'(TAP_A);
    assign rd_addr[1] = rd_lo - WIN_AW'(TAP_B);
    assign rd_addr[2] = rd_lo - WIN_AW'(TAP_C);
    assign rd_addr[3] = rd_lo;

    assign sched_w = (round_reg < ROUND_W'(WIN_DEPTH)) ? rd_data[0]
                   : rd_data[0] ^ rd_data[1] ^ rd_data[2] ^ rd_data[3];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = round_reg[WIN_AW-1:0];
        wr_data = sched_w;
        if (word_acc)
        begin
            wr_en   = 1'b1;
            wr_addr = load_idx;
            wr_data = word.message_word;
        end
        else if (state_reg == S_ROUND && round_reg >= ROUND_W'(WIN_DEPTH))
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        word_idx_next = word_idx_reg;
        round_next    = round_reg;
        emit_next     = emit_reg;
        end_pend_next = end_pend_reg;
        ctl           = '0;
        ctl.round_idx = round_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (word_acc)
                begin
                    ctl.init_iv = word.start_of_message;
                    if (load_idx == WIN_AW'(WIN_DEPTH - 1))
                    begin
                        ctl.load_work = 1'b1;
                        word_idx_next = '0;
                        round_next    = '0;
                        end_pend_next = word.end_of_message;
                        state_next    = S_ROUND;
                    end
                    else if (word.end_of_message)
                    begin
                        word_idx_next = '0;
                        emit_next     = '0;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        word_idx_next = load_idx + WIN_AW'(1);
                    end
                end
            end
            S_ROUND:
            begin
                ctl.round_en = 1'b1;
                round_next   = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_W'(NUM_ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                ctl.add_chain = 1'b1;
                emit_next     = '0;
                state_next    = end_pend_reg ? S_EMIT : S_LOAD;
            end
            S_EMIT:
            begin
                if (digest_acc)
                begin
                    emit_next = emit_reg + CHAIN_IW'(1);
                    if (emit_reg == CHAIN_IW'(CHAIN_WORDS - 1))
                    begin
                        emit_next  = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            word_idx_reg <= '0;
            round_reg    <= '0;
            emit_reg     <= '0;
            end_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_idx_reg <= word_idx_next;
            round_reg    <= round_next;
            emit_reg     <= emit_next;
            end_pend_reg <= end_pend_next;
        end
    end

    sha0_sched_mem u_sched (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sha0_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .w           (sched_w),
        .sel         (emit_reg),
        .digest_word (digest.digest_word)
    );

    assign digest.digest_last = (emit_reg == CHAIN_IW'(CHAIN_WORDS - 1));

`include "sha0_compression_assert.svh"

    `SHA0_ASSERT_IMP(a_add_after_last_round, state_reg == S_ADD,
        $past(state_reg) == S_ROUND && $past(round_reg) == ROUND_W'(NUM_ROUNDS - 1),
        "add cycle not preceded by final round")
    `SHA0_ASSERT_NXT(a_last_beat_to_load, digest_acc && digest.digest_last,
        state_reg == S_LOAD, "digest did not end after last beat")
    `SHA0_ASSERT_IMP(a_emit_block_aligned, state_reg == S_EMIT,
        word_idx_reg == '0, "block position not cleared during digest")
    `SHA0_ASSERT_IMP(a_round_starts_at_zero,
        state_reg == S_ROUND && $past(state_reg) == S_LOAD,
        round_reg == '0, "compression did not start at round zero")

endmodule

/* rtl/core/sha0_sched_mem.sv */
// ---------------------------------------------------------------------------
// sha0_sched_mem
// 16-word message schedule window, two mirrored copies, four registered reads.
// ---------------------------------------------------------------------------
module sha0_sched_mem (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [sha0_pkg::WIN_AW-1:0]                 wr_addr,
    input  logic [sha0_pkg::WORD_W-1:0]                 wr_data,
    input  logic [sha0_pkg::RD_PORTS-1:0][sha0_pkg::WIN_AW-1:0] rd_addr,
    output logic [sha0_pkg::RD_PORTS-1:0][sha0_pkg::WORD_W-1:0] rd_data
);
    import sha0_pkg::*;

    // each copy: one write port, two read ports
    logic [WORD_W-1:0] mem_a [WIN_DEPTH];
    logic [WORD_W-1:0] mem_b [WIN_DEPTH];
    logic [RD_PORTS-1:0][WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
        end
        rd_data_reg[0] <= mem_a[rd_addr[0]];
        rd_data_reg[1] <= mem_a[rd_addr[1]];
        rd_data_reg[2] <= mem_b[rd_addr[2]];
        rd_data_reg[3] <= mem_b[rd_addr[3]];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/sha0_round.sv */
// ---------------------------------------------------------------------------
// sha0_round
// Working words a..e, one SHA-0 round per cycle while round_en is set, and the chaining words.
// ---------------------------------------------------------------------------
module sha0_round (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sha0_pkg::rnd_ctl_t             ctl,
    input  logic [sha0_pkg::WORD_W-1:0]    w,
    input  logic [sha0_pkg::CHAIN_IW-1:0]  sel,
    output logic [sha0_pkg::WORD_W-1:0]    digest_word
);
    import sha0_pkg::*;

    logic [WORD_W-1:0] chain_reg [CHAIN_WORDS];
    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0] f, k, tmp;

    always_comb
    begin
        if (ctl.round_idx < ROUND_W'(PHASE1_END))
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = K0;
        end
        else if (ctl.round_idx < ROUND_W'(PHASE2_END))
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K1;
        end
        else if (ctl.round_idx < ROUND_W'(PHASE3_END))
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = K2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = K3;
        end
        tmp = {a_reg[WORD_W-6:0], a_reg[WORD_W-1:WORD_W-5]} + f + e_reg + k + w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_reg[i] <= IV_WORDS[i];
            end
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
            e_reg <= '0;
        end
        else
        begin
            if (ctl.init_iv)
            begin
                for (int i = 0; i < CHAIN_WORDS; i++)
                begin
                    chain_reg[i] <= IV_WORDS[i];
                end
            end
            else if (ctl.add_chain)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end

            if (ctl.load_work)
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
            else if (ctl.round_en)
            begin
                a_reg <= tmp;
                b_reg <= a_reg;
                c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
                d_reg <= c_reg;
                e_reg <= d_reg;
            end
        end
    end

    assign digest_word = (sel < CHAIN_IW'(CHAIN_WORDS)) ? chain_reg[sel] : '0;

endmodule
